// ===== design/fbfl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed block free list allocator package
// Shared codes, configuration register layout and default sizes.
// ----------------------------------------------------------------------------
package fbfl_pkg;

  localparam int DEF_MAX_BLOCKS = 256;

  localparam int MODE_W      = 2;
  localparam int REQ_W       = 16;
  localparam int INDEX_W     = 8;
  localparam int STATUS_W    = 3;
  localparam int USED_W      = 21;
  localparam int SIZE_W      = 13;
  localparam int COUNT_W     = 9;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_SIZE_ERR  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_ALIGN_ERR = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_RANGE_ERR = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_SIZE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_ALIGN = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_COUNT = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [SIZE_W-1:0]  RST_BLOCK_SIZE  = 13'd64;
  localparam logic [SIZE_W-1:0]  RST_BLOCK_ALIGN = 13'd8;
  localparam logic [COUNT_W-1:0] RST_BLOCK_COUNT = 9'd256;

  typedef struct packed {
    logic [SIZE_W-1:0]  block_size;
    logic [SIZE_W-1:0]  block_align;
    logic [COUNT_W-1:0] block_count;
  } cfg_t;

endpackage

// ===== design/fbfl_link_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free list link memory
// Simple dual port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fbfl_link_mem #(
  parameter int DEPTH  = fbfl_pkg::DEF_MAX_BLOCKS,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int DATA_W = ADDR_W + 1
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/fbfl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free list controller
// Sequences allocate, free and clear against the link memory and holds the
// free list head, the used byte count and the result register.
// ----------------------------------------------------------------------------
module fbfl_ctrl #(
  parameter int MAX_BLOCKS = fbfl_pkg::DEF_MAX_BLOCKS,
  parameter int ADDR_W     = $clog2(MAX_BLOCKS),
  parameter int LINK_W     = ADDR_W + 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fbfl_pkg::cfg_t                 cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [fbfl_pkg::MODE_W-1:0]    in_mode,
  input  logic [fbfl_pkg::REQ_W-1:0]     in_req_size,
  input  logic [fbfl_pkg::REQ_W-1:0]     in_req_align,
  input  logic [fbfl_pkg::INDEX_W-1:0]   in_free_index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [fbfl_pkg::STATUS_W-1:0]  out_status,
  output logic [fbfl_pkg::INDEX_W-1:0]   out_granted_index,
  output logic [fbfl_pkg::USED_W-1:0]    out_used_bytes,
  output logic                           mem_rd_en,
  output logic [ADDR_W-1:0]              mem_rd_addr,
  input  logic [LINK_W-1:0]              mem_rd_data,
  output logic                           mem_wr_en,
  output logic [ADDR_W-1:0]              mem_wr_addr,
  output logic [LINK_W-1:0]              mem_wr_data
);

  localparam int CMP_W = (LINK_W > fbfl_pkg::COUNT_W) ? LINK_W : fbfl_pkg::COUNT_W;
  localparam logic [LINK_W-1:0] LINK_EMPTY = LINK_W'(MAX_BLOCKS);

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_CLEAR = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]                        state_r, state_nxt;
  logic [LINK_W-1:0]                 head_r, head_nxt;
  logic [fbfl_pkg::USED_W-1:0]       used_r, used_nxt;
  logic [ADDR_W-1:0]                 cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]                 last_r, last_nxt;

  logic [fbfl_pkg::MODE_W-1:0]       mode_r;
  logic [fbfl_pkg::REQ_W-1:0]        size_r;
  logic [fbfl_pkg::REQ_W-1:0]        align_r;
  logic [fbfl_pkg::INDEX_W-1:0]      fidx_r;

  logic                              out_valid_r, out_valid_nxt;
  logic [fbfl_pkg::STATUS_W-1:0]     out_status_r, out_status_nxt;
  logic [fbfl_pkg::INDEX_W-1:0]      out_index_r, out_index_nxt;
  logic [fbfl_pkg::USED_W-1:0]       out_used_r, out_used_nxt;

  logic                              accept;
  logic                              slot_free;
  logic                              emit;
  logic                              head_empty;
  logic                              size_bad;
  logic                              align_bad;
  logic                              exec_err;
  logic [CMP_W-1:0]                  eff_count;
  logic [CMP_W-1:0]                  count_ext;
  logic                              sweeping;
  logic                              sweep_end;
  logic [fbfl_pkg::USED_W-1:0]       bsize_ext;

  assign accept     = in_valid && in_ready;
  assign in_ready   = (state_r == ST_IDLE);
  assign slot_free  = !out_valid_r || out_ready;
  assign head_empty = (head_r >= LINK_EMPTY);
  assign size_bad   = (size_r != fbfl_pkg::REQ_W'(cfg.block_size));
  assign align_bad  = (align_r != fbfl_pkg::REQ_W'(cfg.block_align));
  assign count_ext  = CMP_W'(cfg.block_count);
  assign eff_count  = (count_ext > CMP_W'(MAX_BLOCKS)) ? CMP_W'(MAX_BLOCKS) : count_ext;
  assign sweeping   = (state_r == ST_INIT) || (state_r == ST_CLEAR);
  assign sweep_end  = (cnt_r == last_r);
  assign bsize_ext  = fbfl_pkg::USED_W'(cfg.block_size);

  // Head entry is read on the accept edge; its link is ready in EXEC.
  assign mem_rd_en   = accept && !head_empty;
  assign mem_rd_addr = ADDR_W'(head_r);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    used_nxt       = used_r;
    cnt_nxt        = cnt_r;
    last_nxt       = last_r;
    emit           = 1'b0;
    exec_err       = 1'b0;
    out_status_nxt = fbfl_pkg::STAT_OK;
    out_index_nxt  = '0;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = cnt_r;
    mem_wr_data    = sweep_end ? LINK_EMPTY : (LINK_W'(cnt_r) + LINK_W'(1));

    case (state_r)
      ST_INIT, ST_CLEAR: begin
        mem_wr_en = 1'b1;
        cnt_nxt   = cnt_r + ADDR_W'(1);
        if (sweep_end) begin
          state_nxt = (state_r == ST_INIT) ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
          emit      = 1'b1;
          case (mode_r)
            fbfl_pkg::MODE_ALLOC: begin
              if (head_empty) begin
                out_status_nxt = fbfl_pkg::STAT_EMPTY;
                exec_err       = 1'b1;
              end else if (size_bad) begin
                out_status_nxt = fbfl_pkg::STAT_SIZE_ERR;
                exec_err       = 1'b1;
              end else if (align_bad) begin
                out_status_nxt = fbfl_pkg::STAT_ALIGN_ERR;
                exec_err       = 1'b1;
              end else begin
                out_index_nxt = fbfl_pkg::INDEX_W'(head_r);
                head_nxt      = mem_rd_data;
                used_nxt      = used_r + bsize_ext;
              end
            end
            fbfl_pkg::MODE_FREE: begin
              if (size_bad) begin
                out_status_nxt = fbfl_pkg::STAT_SIZE_ERR;
                exec_err       = 1'b1;
              end else if (align_bad) begin
                out_status_nxt = fbfl_pkg::STAT_ALIGN_ERR;
                exec_err       = 1'b1;
              end else if (CMP_W'(fidx_r) >= eff_count) begin
                out_status_nxt = fbfl_pkg::STAT_RANGE_ERR;
                exec_err       = 1'b1;
              end else begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = ADDR_W'(fidx_r);
                mem_wr_data = head_r;
                head_nxt    = LINK_W'(fidx_r);
                used_nxt    = used_r - bsize_ext;
              end
            end
            fbfl_pkg::MODE_CLEAR: begin
              used_nxt = '0;
              if (eff_count == '0) begin
                head_nxt = LINK_EMPTY;
              end else begin
                emit      = 1'b0;
                head_nxt  = '0;
                cnt_nxt   = '0;
                last_nxt  = ADDR_W'(eff_count - CMP_W'(1));
                state_nxt = ST_CLEAR;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_used_nxt = used_nxt;

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      head_r      <= '0;
      used_r      <= '0;
      cnt_r       <= '0;
      last_r      <= ADDR_W'(MAX_BLOCKS - 1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      used_r      <= used_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_mode;
      size_r  <= in_req_size;
      align_r <= in_req_align;
      fidx_r  <= in_free_index;
    end
    if (emit) begin
      out_status_r <= out_status_nxt;
      out_index_r  <= out_index_nxt;
      out_used_r   <= out_used_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_index = out_index_r;
  assign out_used_bytes    = out_used_r;

  // The link memory is never read and written in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_rd_en && mem_wr_en))
    else $error("link memory read and write overlap");

  // A refused request leaves the free list and the byte count alone.
  a_err_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && slot_free && exec_err) |=> ($stable(head_r) && $stable(used_r)))
    else $error("refused request changed allocator state");

  // No item is taken while the link chain is being rebuilt.
  a_no_accept_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    sweeping |-> !accept)
    else $error("item accepted during chain rebuild");

  // A clear that rebuilt the chain reports zero used bytes and leaves the head at block zero.
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && slot_free) |=> (out_valid && out_used_bytes == '0 && head_r == '0))
    else $error("clear result or head is wrong");

endmodule

// ===== design/fixed_block_free_list_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed block free list allocator
// Pool of equal-sized blocks kept as a linked free list in a link memory.
// ----------------------------------------------------------------------------
// Allocate and free: the head link is read as the item is taken; once the
// result slot is free the result is registered and, on success, the list
// updated. Only then is the next item taken. Clear: one link is written per
// cycle over the effective block count, then the result. After reset the
// chain of MAX_BLOCKS links is built with in_ready low, taking config writes.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator #(
  parameter int MAX_BLOCKS = fbfl_pkg::DEF_MAX_BLOCKS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [fbfl_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [fbfl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // Request channel.
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [fbfl_pkg::MODE_W-1:0]       in_mode,
  input  logic [fbfl_pkg::REQ_W-1:0]        in_req_size,
  input  logic [fbfl_pkg::REQ_W-1:0]        in_req_align,
  input  logic [fbfl_pkg::INDEX_W-1:0]      in_free_index,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fbfl_pkg::STATUS_W-1:0]     out_status,
  output logic [fbfl_pkg::INDEX_W-1:0]      out_granted_index,
  output logic [fbfl_pkg::USED_W-1:0]       out_used_bytes
);

  // The link memory holds one entry per block. Each link is one bit wider
  // than a block index so that the code MAX_BLOCKS can mark the list end.
  localparam int ADDR_W = $clog2(MAX_BLOCKS);
  localparam int LINK_W = ADDR_W + 1;

  fbfl_pkg::cfg_t cfg_r, cfg_nxt;

  logic              mem_rd_en;
  logic [ADDR_W-1:0] mem_rd_addr;
  logic [LINK_W-1:0] mem_rd_data;
  logic              mem_wr_en;
  logic [ADDR_W-1:0] mem_wr_addr;
  logic [LINK_W-1:0] mem_wr_data;

  // Configuration registers. Writing the block count does not rebuild the
  // list; only a clear item does. Unused indexes are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        fbfl_pkg::REG_BLOCK_SIZE:  cfg_nxt.block_size  = cfg_wdata;
        fbfl_pkg::REG_BLOCK_ALIGN: cfg_nxt.block_align = cfg_wdata;
        fbfl_pkg::REG_BLOCK_COUNT: cfg_nxt.block_count = cfg_wdata[fbfl_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_size  <= fbfl_pkg::RST_BLOCK_SIZE;
      cfg_r.block_align <= fbfl_pkg::RST_BLOCK_ALIGN;
      cfg_r.block_count <= fbfl_pkg::RST_BLOCK_COUNT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The controller owns the head pointer, the used byte count and the
  // result register, so a finished result can wait while the next item
  // is taken. It drives the memory for the head read, the link push on
  // free, and the one-link-per-cycle rebuild on reset and clear.
  fbfl_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .ADDR_W     (ADDR_W),
    .LINK_W     (LINK_W)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_req_size       (in_req_size),
    .in_req_align      (in_req_align),
    .in_free_index     (in_free_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_granted_index (out_granted_index),
    .out_used_bytes    (out_used_bytes),
    .mem_rd_en         (mem_rd_en),
    .mem_rd_addr       (mem_rd_addr),
    .mem_rd_data       (mem_rd_data),
    .mem_wr_en         (mem_wr_en),
    .mem_wr_addr       (mem_wr_addr),
    .mem_wr_data       (mem_wr_data)
  );

  // Link memory: the free list itself, one next pointer per block.
  fbfl_link_mem #(
    .DEPTH  (MAX_BLOCKS),
    .ADDR_W (ADDR_W),
    .DATA_W (LINK_W)
  ) u_link_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

endmodule

// ===== dv/tb_fixed_block_free_list_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the fixed block free list allocator
// Drives allocate, free, clear and ignored requests through the valid/ready
// request channel under several pool settings. A local copy of the free list
// forecasts the status, granted index and used-byte count of each result.
// Every result is compared against that forecast in order.
// ----------------------------------------------------------------------------
module tb_fixed_block_free_list_allocator;

  // Mode value that the block takes but ignores.
  localparam logic [fbfl_pkg::MODE_W-1:0] MODE_NONE = 2'd3;
  // Link value that marks the end of the free chain.
  localparam logic [fbfl_pkg::COUNT_W-1:0] EMPTY_LINK =
    fbfl_pkg::COUNT_W'(fbfl_pkg::DEF_MAX_BLOCKS);
  // Cycles with no handshake on either channel before the run is abandoned.
  // The slowest legal stretch is a clear of a full pool or the quiet tail
  // at the end of the run, so this leaves a wide margin.
  localparam int QUIET_LIMIT = 5000;
  localparam int TAIL_CYCLES = 300;
  localparam int RANDOM_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 175;

  typedef struct {
    logic [fbfl_pkg::MODE_W-1:0]  mode;
    logic [fbfl_pkg::REQ_W-1:0]   req_size;
    logic [fbfl_pkg::REQ_W-1:0]   req_align;
    logic [fbfl_pkg::INDEX_W-1:0] free_index;
    bit                           pick_live;   // free a block that is currently granted
    bit                           wait_drain;  // hold this item until all results are in
  } pool_req_t;

  typedef struct packed {
    logic [fbfl_pkg::STATUS_W-1:0] status;
    logic [fbfl_pkg::INDEX_W-1:0]  granted;
    logic [fbfl_pkg::USED_W-1:0]   used;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [fbfl_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [fbfl_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  logic [fbfl_pkg::MODE_W-1:0] in_mode;
  logic [fbfl_pkg::REQ_W-1:0] in_req_size;
  logic [fbfl_pkg::REQ_W-1:0] in_req_align;
  logic [fbfl_pkg::INDEX_W-1:0] in_free_index;
  logic out_valid;
  logic out_ready;
  logic [fbfl_pkg::STATUS_W-1:0] out_status;
  logic [fbfl_pkg::INDEX_W-1:0] out_granted_index;
  logic [fbfl_pkg::USED_W-1:0] out_used_bytes;

  fixed_block_free_list_allocator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_req_size      (in_req_size),
    .in_req_align     (in_req_align),
    .in_free_index    (in_free_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_granted_index(out_granted_index),
    .out_used_bytes   (out_used_bytes)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the pool: the link memory, the head of the free chain, the
  // used-byte total and the register values the block currently holds.
  fbfl_pkg::cfg_t                pool_cfg;
  logic [fbfl_pkg::COUNT_W-1:0]  link_mem [fbfl_pkg::DEF_MAX_BLOCKS];
  logic [fbfl_pkg::COUNT_W-1:0]  free_head;
  logic [fbfl_pkg::USED_W-1:0]   used_total;
  // Blocks granted and not yet returned, so that frees can target them.
  logic [fbfl_pkg::INDEX_W-1:0]  live_blocks[$];

  pool_req_t     pending_reqs[$];
  alloc_result_t expected_results[$];
  pool_req_t     cur_req;
  bit            in_hold = 1'b0;  // an item is on the request port
  int            mismatches = 0;
  int            quiet_cycles = 0;

  // Lays the free chain out as 0, 1, ..., n-1. With no blocks the head
  // points at the end marker straight away.
  function automatic void rebuild_free_chain(int n);
    if (n == 0) begin
      free_head = EMPTY_LINK;
    end else begin
      for (int i = 0; i < n - 1; i++) link_mem[i] = fbfl_pkg::COUNT_W'(i + 1);
      link_mem[n-1] = EMPTY_LINK;
      free_head = '0;
    end
  endfunction

  // Applies one request to the local pool and returns the result the block
  // must produce. Any error leaves the pool untouched and grants index 0.
  function automatic alloc_result_t predict_pool_step(pool_req_t req);
    alloc_result_t res;
    int eff_count;
    eff_count = (pool_cfg.block_count > fbfl_pkg::DEF_MAX_BLOCKS) ?
                fbfl_pkg::DEF_MAX_BLOCKS : int'(pool_cfg.block_count);
    res.status = fbfl_pkg::STAT_OK;
    res.granted = '0;
    case (req.mode)
      fbfl_pkg::MODE_ALLOC: begin
        // An empty pool wins over any mismatch in the request.
        if (free_head >= fbfl_pkg::DEF_MAX_BLOCKS) begin
          res.status = fbfl_pkg::STAT_EMPTY;
        end else if (req.req_size != fbfl_pkg::REQ_W'(pool_cfg.block_size)) begin
          res.status = fbfl_pkg::STAT_SIZE_ERR;
        end else if (req.req_align != fbfl_pkg::REQ_W'(pool_cfg.block_align)) begin
          res.status = fbfl_pkg::STAT_ALIGN_ERR;
        end else begin
          res.granted = free_head[fbfl_pkg::INDEX_W-1:0];
          live_blocks.push_back(free_head[fbfl_pkg::INDEX_W-1:0]);
          free_head = link_mem[free_head[fbfl_pkg::INDEX_W-1:0]];
          used_total = used_total + fbfl_pkg::USED_W'(pool_cfg.block_size);
        end
      end
      fbfl_pkg::MODE_FREE: begin
        if (req.req_size != fbfl_pkg::REQ_W'(pool_cfg.block_size)) begin
          res.status = fbfl_pkg::STAT_SIZE_ERR;
        end else if (req.req_align != fbfl_pkg::REQ_W'(pool_cfg.block_align)) begin
          res.status = fbfl_pkg::STAT_ALIGN_ERR;
        end else if (req.free_index >= eff_count) begin
          res.status = fbfl_pkg::STAT_RANGE_ERR;
        end else begin
          // A double free is taken as is: the index goes on the head again,
          // which may leave the chain looping on itself.
          link_mem[req.free_index] = free_head;
          free_head = {1'b0, req.free_index};
          used_total = used_total - fbfl_pkg::USED_W'(pool_cfg.block_size);
          for (int i = 0; i < live_blocks.size(); i++) begin
            if (live_blocks[i] == req.free_index) begin
              live_blocks.delete(i);
              break;
            end
          end
        end
      end
      fbfl_pkg::MODE_CLEAR: begin
        rebuild_free_chain(eff_count);
        used_total = '0;
        live_blocks.delete();
      end
      default: begin
      end
    endcase
    res.used = used_total;
    return res;
  endfunction

  task automatic add_req(logic [fbfl_pkg::MODE_W-1:0] mode, int size, int align, int index);
    pool_req_t req;
    req.mode = mode;
    req.req_size = fbfl_pkg::REQ_W'(size);
    req.req_align = fbfl_pkg::REQ_W'(align);
    req.free_index = fbfl_pkg::INDEX_W'(index);
    req.pick_live = 1'b0;
    req.wait_drain = 1'b0;
    pending_reqs.push_back(req);
  endtask

  // Returns at a falling edge once nothing is queued, on the port or owed.
  task automatic wait_until_idle();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_hold || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // Writes all three registers on consecutive cycles. Called at a falling
  // edge while the block is idle, so the local copy can follow at once.
  task automatic set_pool_config(int size, int align, int count);
    cfg_we <= 1'b1;
    cfg_index <= fbfl_pkg::REG_BLOCK_SIZE;
    cfg_wdata <= fbfl_pkg::CFG_DATA_W'(size);
    pool_cfg.block_size = fbfl_pkg::SIZE_W'(size);
    @(negedge clk);
    cfg_index <= fbfl_pkg::REG_BLOCK_ALIGN;
    cfg_wdata <= fbfl_pkg::CFG_DATA_W'(align);
    pool_cfg.block_align = fbfl_pkg::SIZE_W'(align);
    @(negedge clk);
    cfg_index <= fbfl_pkg::REG_BLOCK_COUNT;
    cfg_wdata <= fbfl_pkg::CFG_DATA_W'(count);
    pool_cfg.block_count = fbfl_pkg::COUNT_W'(count);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // A corrupted request field: either fully random or one bit off the
  // expected value, so single-bit compare faults are caught too.
  function automatic logic [fbfl_pkg::REQ_W-1:0] skew_field(
    logic [fbfl_pkg::REQ_W-1:0] good);
    if ($urandom_range(0, 1) == 0) return fbfl_pkg::REQ_W'($urandom);
    return good ^ (fbfl_pkg::REQ_W'(1) << $urandom_range(0, fbfl_pkg::REQ_W - 1));
  endfunction

  // Mostly well-formed allocate and free traffic against the current pool,
  // with a share of bad sizes, bad alignments, stray indexes, clears and
  // ignored modes. The allocate share varies so pools both drain and refill.
  task automatic queue_random_phase(int n_items);
    pool_req_t req;
    int alloc_pct;
    int r;
    alloc_pct = $urandom_range(30, 70);
    for (int k = 0; k < n_items; k++) begin
      r = $urandom_range(0, 99);
      req.req_size = fbfl_pkg::REQ_W'(pool_cfg.block_size);
      req.req_align = fbfl_pkg::REQ_W'(pool_cfg.block_align);
      req.free_index = fbfl_pkg::INDEX_W'($urandom);
      req.pick_live = 1'b0;
      req.wait_drain = (k == n_items / 2) || ($urandom_range(0, 99) == 0);
      if (k == 0) begin
        // Usually start from a rebuilt pool; sometimes keep the old chain to
        // see that a count write alone does not rebuild it.
        req.mode = ($urandom_range(0, 3) != 0) ? fbfl_pkg::MODE_CLEAR : fbfl_pkg::MODE_ALLOC;
      end else if (r < 2) begin
        req.mode = fbfl_pkg::MODE_CLEAR;
      end else if (r < 4) begin
        req.mode = MODE_NONE;
      end else if (r < 4 + alloc_pct) begin
        req.mode = fbfl_pkg::MODE_ALLOC;
      end else begin
        req.mode = fbfl_pkg::MODE_FREE;
        req.pick_live = ($urandom_range(0, 99) < 85);
      end
      if (req.mode == fbfl_pkg::MODE_ALLOC || req.mode == fbfl_pkg::MODE_FREE) begin
        r = $urandom_range(0, 99);
        if (r < 7) req.req_size = skew_field(req.req_size);
        else if (r < 14) req.req_align = skew_field(req.req_align);
      end else begin
        req.req_size = fbfl_pkg::REQ_W'($urandom);
        req.req_align = fbfl_pkg::REQ_W'($urandom);
      end
      pending_reqs.push_back(req);
    end
  endtask

  // Request driver. Items go out in bursts of random length separated by
  // random gaps, and an item marked to wait holds back until the block has
  // returned every result it owes.
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin
    if (!in_hold) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0 &&
                   !(pending_reqs[0].wait_drain && expected_results.size() != 0)) begin
        cur_req = pending_reqs.pop_front();
        if (cur_req.pick_live && live_blocks.size() != 0)
          cur_req.free_index = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
        in_valid <= 1'b1;
        in_mode <= cur_req.mode;
        in_req_size <= cur_req.req_size;
        in_req_align <= cur_req.req_align;
        in_free_index <= cur_req.free_index;
        in_hold = 1'b1;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The forecast is taken at the edge that accepts the item, so it always
  // sees the pool as left by every earlier item.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      expected_results.push_back(predict_pool_step(cur_req));
      in_hold = 1'b0;
    end
  end

  // Result receiver. Ready follows a rotating 8-bit pattern that is redrawn
  // whenever the 5-bit age counter wraps; a quarter of the patterns never stall.
  logic [7:0] ready_pat = 8'hFF;
  logic [4:0] pat_age = '0;

  always @(negedge clk) begin
    if (pat_age == 0)
      ready_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
    pat_age = pat_age + 5'd1;
    out_ready <= ready_pat[0];
    ready_pat = {ready_pat[0], ready_pat[7:1]};
  end

  task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  // Result checker: each accepted result against the oldest forecast.
  alloc_result_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t ns: result with nothing expected, status %0d index %0d used %0d",
                 $time, out_status, out_granted_index, out_used_bytes);
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status)
          flag_mismatch("status", 32'(want.status), 32'(out_status));
        if (out_granted_index !== want.granted)
          flag_mismatch("granted index", 32'(want.granted), 32'(out_granted_index));
        if (out_used_bytes !== want.used)
          flag_mismatch("used bytes", 32'(want.used), 32'(out_used_bytes));
      end
    end
  end

  // Watchdog: counts cycles after reset in which neither channel moves.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else if (rst_n) quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk);
    $display("%0t ns: no handshake for %0d cycles", $time, QUIET_LIMIT);
    $display("[fixed_block_free_list_allocator] ERROR");
    $finish;
  end

  // Main sequence: reset, a directed pass through the special cases, then
  // random phases, each under its own register settings.
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_mode = '0;
    in_req_size = '0;
    in_req_align = '0;
    in_free_index = '0;
    out_ready = 1'b0;
    pool_cfg.block_size = fbfl_pkg::RST_BLOCK_SIZE;
    pool_cfg.block_align = fbfl_pkg::RST_BLOCK_ALIGN;
    pool_cfg.block_count = fbfl_pkg::RST_BLOCK_COUNT;
    rebuild_free_chain(fbfl_pkg::DEF_MAX_BLOCKS);
    used_total = '0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: size 64, alignment 8, full pool. Checks the error
    // order for both commands, the ignored mode, a double free with the
    // used count wrapping below zero, and the loop that a double free makes.
    add_req(fbfl_pkg::MODE_ALLOC, 64, 8, 0);
    add_req(fbfl_pkg::MODE_ALLOC, 0, 8, 0);
    add_req(fbfl_pkg::MODE_ALLOC, 65535, 0, 0);
    add_req(fbfl_pkg::MODE_ALLOC, 64, 65535, 0);
    add_req(MODE_NONE, 65535, 65535, 255);
    add_req(fbfl_pkg::MODE_FREE, 0, 0, 0);
    add_req(fbfl_pkg::MODE_FREE, 64, 0, 255);
    add_req(fbfl_pkg::MODE_FREE, 64, 8, 0);
    add_req(fbfl_pkg::MODE_FREE, 64, 8, 0);
    add_req(fbfl_pkg::MODE_ALLOC, 64, 8, 0);
    add_req(fbfl_pkg::MODE_ALLOC, 64, 8, 0);
    add_req(fbfl_pkg::MODE_CLEAR, 0, 0, 0);

    // Two-block pool of single bytes: a stale chain until the clear, then
    // running dry, empty reported ahead of a size mismatch, out-of-range frees.
    wait_until_idle();
    set_pool_config(1, 1, 2);
    @(posedge clk);
    add_req(fbfl_pkg::MODE_FREE, 1, 1, 2);
    add_req(fbfl_pkg::MODE_CLEAR, 0, 0, 0);
    add_req(fbfl_pkg::MODE_ALLOC, 1, 1, 0);
    add_req(fbfl_pkg::MODE_ALLOC, 1, 1, 0);
    add_req(fbfl_pkg::MODE_ALLOC, 1, 1, 0);
    add_req(fbfl_pkg::MODE_ALLOC, 0, 0, 0);
    add_req(fbfl_pkg::MODE_FREE, 1, 1, 255);
    add_req(fbfl_pkg::MODE_FREE, 1, 1, 1);

    // Zero registers: a clear leaves the pool empty and every free is out of
    // range.
    wait_until_idle();
    set_pool_config(0, 0, 0);
    @(posedge clk);
    add_req(fbfl_pkg::MODE_CLEAR, 0, 0, 0);
    add_req(fbfl_pkg::MODE_ALLOC, 0, 0, 0);
    add_req(fbfl_pkg::MODE_FREE, 0, 0, 0);

    // Top register codes: the count saturates at the pool size, but only
    // after a clear rebuilds the chain.
    wait_until_idle();
    set_pool_config(8191, 4096, 511);
    @(posedge clk);
    add_req(fbfl_pkg::MODE_ALLOC, 8191, 4096, 0);
    add_req(fbfl_pkg::MODE_CLEAR, 0, 0, 0);
    add_req(fbfl_pkg::MODE_ALLOC, 8191, 4096, 0);
    add_req(fbfl_pkg::MODE_FREE, 8191, 4096, 255);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      int size_val;
      int align_val;
      int count_val;
      wait_until_idle();
      case ($urandom_range(0, 3))
        0: size_val = 1;
        1: size_val = 4096;
        2: size_val = $urandom_range(0, 8191);
        default: size_val = $urandom_range(1, 4096);
      endcase
      case ($urandom_range(0, 3))
        0: align_val = 1;
        1: align_val = 4096;
        2: align_val = $urandom_range(0, 8191);
        default: align_val = $urandom_range(1, 4096);
      endcase
      case ($urandom_range(0, 3))
        0: count_val = 1;
        1: count_val = 256;
        2: count_val = $urandom_range(0, 511);
        default: count_val = $urandom_range(2, 16);
      endcase
      // The first two phases pin the range limits.
      if (p == 0) begin
        size_val = 4096;
        align_val = 4096;
        count_val = 256;
      end else if (p == 1) begin
        size_val = 1;
        align_val = 1;
        count_val = 1;
      end
      set_pool_config(size_val, align_val, count_val);
      @(posedge clk);
      queue_random_phase(ITEMS_PER_PHASE);
    end

    // Let a stray late result show up before the verdict.
    wait_until_idle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("[fixed_block_free_list_allocator] OK");
    else
      $display("[fixed_block_free_list_allocator] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
design/fbfl_pkg.sv
design/fbfl_link_mem.sv
design/fbfl_ctrl.sv
design/fixed_block_free_list_allocator.sv
dv/tb_fixed_block_free_list_allocator.sv
